// ===== hw/rtl/tlpc_pkg.sv =====
// Package for the thick line pixel coverage block.
// Holds shared widths, reset values and configuration register indexes.
// No dependencies; compiled before every other file of the block.
package tlpc_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int WIDTH_BITS     = 8;
    localparam int RGB_BITS       = 24;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int WIDTH2_BITS    = 2 * WIDTH_BITS;

    localparam logic [WIDTH_BITS-1:0] BRUSH_WIDTH_RST = WIDTH_BITS'(1);

    // Configuration register indexes, in port order.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_X     = 3'd0,
        CFG_START_Y     = 3'd1,
        CFG_END_X       = 3'd2,
        CFG_END_Y       = 3'd3,
        CFG_BRUSH_WIDTH = 3'd4,
        CFG_BRUSH_RGB   = 3'd5
    } t_cfg_idx;

endpackage

// ===== hw/rtl/tlpc_pix_if.sv =====
// Request channel carrying one pixel coordinate to be tested.
// Uses tlpc_pkg for the default coordinate width.
interface tlpc_pix_if #(
    parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== hw/rtl/tlpc_res_if.sv =====
// Result channel carrying the tested pixel, its coverage flag and the color.
// Uses tlpc_pkg for the default coordinate width and the color width.
interface tlpc_res_if #(
    parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      out_x;
    logic signed [COORD_BITS-1:0]      out_y;
    logic                              paint;
    logic [tlpc_pkg::RGB_BITS-1:0]     out_rgb;

    modport source (output valid, output out_x, output out_y, output paint,
                    output out_rgb, input ready);
    modport sink   (input valid, input out_x, input out_y, input paint,
                    input out_rgb, output ready);
endinterface

// ===== hw/rtl/tlpc_front.sv =====
// Front half of the coverage pipeline: offsets, products, dot and cross terms.
// Three register stages; depends on tlpc_pkg.
module tlpc_front #(
    parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [COORD_BITS-1:0]         i_px,
    input  logic signed [COORD_BITS-1:0]         i_py,
    input  logic signed [COORD_BITS-1:0]         i_sx,
    input  logic signed [COORD_BITS-1:0]         i_sy,
    input  logic signed [COORD_BITS-1:0]         i_ex,
    input  logic signed [COORD_BITS-1:0]         i_ey,
    input  logic [tlpc_pkg::WIDTH_BITS-1:0]      i_w,
    output logic                                 o_valid,
    output logic signed [COORD_BITS-1:0]         o_px,
    output logic signed [COORD_BITS-1:0]         o_py,
    output logic signed [2*COORD_BITS+2:0]       o_dot,
    output logic [2*COORD_BITS+1:0]              o_cabs,
    output logic [2*COORD_BITS+1:0]              o_len2,
    output logic [tlpc_pkg::WIDTH2_BITS-1:0]     o_w2
);
    import tlpc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // Stage 1: offsets from the start point.
    logic                         r_v1;
    logic signed [COORD_BITS-1:0] r_px1, r_py1;
    logic signed [DW-1:0]         r_dx, r_dy, r_qx, r_qy;
    logic [WIDTH_BITS-1:0]        r_w1;
    logic signed [DW-1:0]         n_dx, n_dy, n_qx, n_qy;

    assign n_dx = DW'(i_ex) - DW'(i_sx);
    assign n_dy = DW'(i_ey) - DW'(i_sy);
    assign n_qx = DW'(i_px) - DW'(i_sx);
    assign n_qy = DW'(i_py) - DW'(i_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px1 <= i_px;
            r_py1 <= i_py;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_w1  <= i_w;
        end
    end

    // Stage 2: the six coordinate products and the squared width.
    logic                         r_v2;
    logic signed [COORD_BITS-1:0] r_px2, r_py2;
    logic signed [PW-1:0]         r_dxqx, r_dyqy, r_dxqy, r_dyqx, r_dxdx, r_dydy;
    logic [WIDTH2_BITS-1:0]       r_w2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px2  <= r_px1;
            r_py2  <= r_py1;
            r_dxqx <= PW'(r_dx) * PW'(r_qx);
            r_dyqy <= PW'(r_dy) * PW'(r_qy);
            r_dxqy <= PW'(r_dx) * PW'(r_qy);
            r_dyqx <= PW'(r_dy) * PW'(r_qx);
            r_dxdx <= PW'(r_dx) * PW'(r_dx);
            r_dydy <= PW'(r_dy) * PW'(r_dy);
            r_w2   <= WIDTH2_BITS'(r_w1) * WIDTH2_BITS'(r_w1);
        end
    end

    // Stage 3: dot product, cross magnitude and squared length.
    logic                         r_v3;
    logic signed [COORD_BITS-1:0] r_px3, r_py3;
    logic signed [SW-1:0]         r_dot;
    logic [PW-1:0]                r_cabs, r_len2;
    logic [WIDTH2_BITS-1:0]       r_w2_3;
    logic signed [SW-1:0]         n_dot, n_cross, n_len2;
    logic [PW-1:0]                n_cabs;

    assign n_dot   = SW'(r_dxqx) + SW'(r_dyqy);
    assign n_cross = SW'(r_dxqy) - SW'(r_dyqx);
    assign n_len2  = SW'(r_dxdx) + SW'(r_dydy);
    // The magnitude of the cross term always fits one bit below the sum width.
    assign n_cabs  = n_cross[SW-1] ? PW'(-n_cross) : PW'(n_cross);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px3  <= r_px2;
            r_py3  <= r_py2;
            r_dot  <= n_dot;
            r_cabs <= n_cabs;
            r_len2 <= PW'(n_len2);
            r_w2_3 <= r_w2;
        end
    end

    assign o_valid = r_v3;
    assign o_px    = r_px3;
    assign o_py    = r_py3;
    assign o_dot   = r_dot;
    assign o_cabs  = r_cabs;
    assign o_len2  = r_len2;
    assign o_w2    = r_w2_3;

endmodule

// ===== hw/rtl/tlpc_test.sv =====
// Back half of the coverage pipeline: the span test and the width test.
// Squares are built from half-width partial products; depends on tlpc_pkg.
module tlpc_test #(
    parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [COORD_BITS-1:0]         i_px,
    input  logic signed [COORD_BITS-1:0]         i_py,
    input  logic signed [2*COORD_BITS+2:0]       i_dot,
    input  logic [2*COORD_BITS+1:0]              i_cabs,
    input  logic [2*COORD_BITS+1:0]              i_len2,
    input  logic [tlpc_pkg::WIDTH2_BITS-1:0]     i_w2,
    output logic                                 o_valid,
    output logic signed [COORD_BITS-1:0]         o_px,
    output logic signed [COORD_BITS-1:0]         o_py,
    output logic                                 o_paint
);
    import tlpc_pkg::*;

    localparam int L  = COORD_BITS + 1;   // half width of a magnitude
    localparam int H  = 2 * L;            // magnitude width
    localparam int SW = H + 1;            // signed dot width
    localparam int MW = WIDTH2_BITS + L;  // width-square by half-length product
    localparam int QW = 2 * H + 2;        // compare width

    // Stage 4: span check and partial products.
    logic                         r_v4;
    logic signed [COORD_BITS-1:0] r_px4, r_py4;
    logic                         r_span4;
    logic [H-1:0]                 r_hh, r_hl, r_ll;
    logic [MW-1:0]                r_wh, r_wl;
    logic                         n_span;
    logic [L-1:0]                 c_hi, c_lo, l_hi, l_lo;

    assign c_hi = i_cabs[H-1:L];
    assign c_lo = i_cabs[L-1:0];
    assign l_hi = i_len2[H-1:L];
    assign l_lo = i_len2[L-1:0];

    // A zero-length segment covers nothing; otherwise the projection must land
    // between the end points, both included.
    assign n_span = (i_len2 != '0) && !i_dot[SW-1] && (i_dot[H-1:0] <= i_len2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px4   <= i_px;
            r_py4   <= i_py;
            r_span4 <= n_span;
            r_hh    <= H'(c_hi) * H'(c_hi);
            r_hl    <= H'(c_hi) * H'(c_lo);
            r_ll    <= H'(c_lo) * H'(c_lo);
            r_wh    <= MW'(i_w2) * MW'(l_hi);
            r_wl    <= MW'(i_w2) * MW'(l_lo);
        end
    end

    // Stage 5: assemble 4*cross^2 and width^2*len^2.
    logic                         r_v5;
    logic signed [COORD_BITS-1:0] r_px5, r_py5;
    logic                         r_span5;
    logic [QW-1:0]                r_lhs, r_rhs;
    logic [QW-1:0]                n_sq;

    // hh and ll do not overlap, so they concatenate; the cross term is doubled.
    assign n_sq = QW'({r_hh, r_ll}) + (QW'(r_hl) << (L + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px5   <= r_px4;
            r_py5   <= r_py4;
            r_span5 <= r_span4;
            r_lhs   <= n_sq << 2;
            r_rhs   <= (QW'(r_wh) << L) + QW'(r_wl);
        end
    end

    assign o_valid = r_v5;
    assign o_px    = r_px5;
    assign o_py    = r_py5;
    assign o_paint = r_span5 && (r_lhs <= r_rhs);

endmodule

// ===== hw/rtl/thick_line_pixel_coverage.sv =====
// Top level of the thick line pixel coverage block.
// Depends on tlpc_pkg, tlpc_pix_if, tlpc_res_if, tlpc_front and tlpc_test.
//
// Usage: software writes the segment end points, the brush width and the brush
// color through the configuration write port while no request is in flight.
// Each request on i_pix carries one pixel coordinate; each result on o_res
// carries the same coordinate, a paint flag that is set when the pixel lies
// in the closed rectangle of the brush width centred on the segment, and the
// brush color. A zero-length segment paints nothing.
//
// Throughput is one request per cycle unless the output stalls: five
// arithmetic stages (offsets, products, dot and cross terms, partial squares,
// final squares) feed one output register, and a new request may enter every
// cycle while no result is stalled at the output.
//
// Reset clears all stage valid bits and the output valid bit, and loads the
// configuration registers with their reset values (brush width one, everything else zero).
// When the receiver stalls a valid result, the whole pipeline holds in place
// and i_pix.ready drops in the same cycle; nothing is lost or repeated.
module thick_line_pixel_coverage #(
    parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tlpc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [tlpc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    tlpc_pix_if.sink                             i_pix,
    tlpc_res_if.source                           o_res
);
    import tlpc_pkg::*;

    localparam int H  = 2 * COORD_BITS + 2;
    localparam int SW = H + 1;

    // Configuration registers.
    logic signed [COORD_BITS-1:0] r_start_x, r_start_y, r_end_x, r_end_y;
    logic [WIDTH_BITS-1:0]        r_brush_width;
    logic [RGB_BITS-1:0]          r_brush_rgb;

    // Indexes beyond the register list are ignored; upper data bits are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_end_x       <= '0;
            r_end_y       <= '0;
            r_brush_width <= BRUSH_WIDTH_RST;
            r_brush_rgb   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_X:     r_start_x     <= i_cfg_data[COORD_BITS-1:0];
                CFG_START_Y:     r_start_y     <= i_cfg_data[COORD_BITS-1:0];
                CFG_END_X:       r_end_x       <= i_cfg_data[COORD_BITS-1:0];
                CFG_END_Y:       r_end_y       <= i_cfg_data[COORD_BITS-1:0];
                CFG_BRUSH_WIDTH: r_brush_width <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_BRUSH_RGB:   r_brush_rgb   <= i_cfg_data[RGB_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together whenever the output register is
    // free or is being emptied in this cycle.
    logic r_out_valid;
    logic adv;

    assign adv         = !r_out_valid || o_res.ready;
    assign i_pix.ready = adv;

    logic                         f_valid;
    logic signed [COORD_BITS-1:0] f_px, f_py;
    logic signed [SW-1:0]         f_dot;
    logic [H-1:0]                 f_cabs, f_len2;
    logic [WIDTH2_BITS-1:0]       f_w2;

    tlpc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_pix.valid),
        .i_px    (i_pix.pixel_x),
        .i_py    (i_pix.pixel_y),
        .i_sx    (r_start_x),
        .i_sy    (r_start_y),
        .i_ex    (r_end_x),
        .i_ey    (r_end_y),
        .i_w     (r_brush_width),
        .o_valid (f_valid),
        .o_px    (f_px),
        .o_py    (f_py),
        .o_dot   (f_dot),
        .o_cabs  (f_cabs),
        .o_len2  (f_len2),
        .o_w2    (f_w2)
    );

    logic                         t_valid;
    logic signed [COORD_BITS-1:0] t_px, t_py;
    logic                         t_paint;

    tlpc_test #(
        .COORD_BITS (COORD_BITS)
    ) u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (f_valid),
        .i_px    (f_px),
        .i_py    (f_py),
        .i_dot   (f_dot),
        .i_cabs  (f_cabs),
        .i_len2  (f_len2),
        .i_w2    (f_w2),
        .o_valid (t_valid),
        .o_px    (t_px),
        .o_py    (t_py),
        .o_paint (t_paint)
    );

    // Output register: holds a result until the receiver takes it.
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;
    logic                         r_paint;
    logic [RGB_BITS-1:0]          r_out_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_x   <= t_px;
            r_out_y   <= t_py;
            r_paint   <= t_paint;
            r_out_rgb <= r_brush_rgb;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.out_x   = r_out_x;
    assign o_res.out_y   = r_out_y;
    assign o_res.paint   = r_paint;
    assign o_res.out_rgb = r_out_rgb;

endmodule

// ===== hw/rtl/tlpc_checker.sv =====
// Port-level checks for the thick line pixel coverage block.
// Depends on tlpc_pkg; bound to thick_line_pixel_coverage at the end of the file.
module tlpc_checker #(
    parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [COORD_BITS-1:0]             i_out_x,
    input logic [COORD_BITS-1:0]             i_out_y,
    input logic                              i_out_paint,
    input logic [tlpc_pkg::RGB_BITS-1:0]     i_out_rgb
);
    import tlpc_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A stalled result stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_x) && $stable(i_out_y)
            && $stable(i_out_paint) && $stable(i_out_rgb))
        else $error("stalled result changed");

    // Requests are refused only while a result is stalled at the output.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("request refused without an output stall");

    // With the receiver always ready, every accepted request yields a result,
    // and no result appears without one.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_ready, 1) && $past(i_out_ready, 2) && $past(i_out_ready, 3)
        && $past(i_out_ready, 4) && $past(i_out_ready, 5) && $past(i_out_ready, 6)
        && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
        && $past(i_rst_n, 4) && $past(i_rst_n, 5) && $past(i_rst_n, 6)
        |-> (i_out_valid == $past(in_acc, 6)))
        else $error("result timing does not match request timing");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind thick_line_pixel_coverage tlpc_checker #(
    .COORD_BITS (COORD_BITS)
) u_tlpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_paint (o_res.paint),
    .i_out_rgb   (o_res.out_rgb)
);

// ===== tb/tb_tlpc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the thick line pixel coverage block: watches the configuration port
// and both channels, predicts each result and compares it field by field.
// Depends on tlpc_pkg, tlpc_pix_if and tlpc_res_if.
module tb_tlpc_checker #(
    parameter int COORD_BITS = tlpc_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tlpc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tlpc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    tlpc_pix_if                                i_pix,
    tlpc_res_if                                i_res,
    output int                                 o_fail_count,
    output int                                 o_outstanding
);
    import tlpc_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         paint;
        logic [RGB_BITS-1:0]          rgb;
    } t_painted_pixel;

    // Local copy of the stroke registers.
    logic signed [COORD_BITS-1:0] seg_x0;
    logic signed [COORD_BITS-1:0] seg_y0;
    logic signed [COORD_BITS-1:0] seg_x1;
    logic signed [COORD_BITS-1:0] seg_y1;
    logic [WIDTH_BITS-1:0]        brush_w;
    logic [RGB_BITS-1:0]          brush_rgb;

    t_painted_pixel awaited_pixels[$];

    // Exact rectangle test: the projection onto the segment must fall between
    // the end points, and twice the perpendicular distance times |d| must not
    // exceed width times |d|, all squared to stay in integers.
    function automatic logic pixel_in_stroke(input logic signed [COORD_BITS-1:0] px,
                                             input logic signed [COORD_BITS-1:0] py);
        longint dx, dy, qx, qy, len2, along, perp, twice, lim;
        dx    = longint'(seg_x1) - longint'(seg_x0);
        dy    = longint'(seg_y1) - longint'(seg_y0);
        qx    = longint'(px) - longint'(seg_x0);
        qy    = longint'(py) - longint'(seg_y0);
        len2  = dx * dx + dy * dy;
        along = dx * qx + dy * qy;
        perp  = dx * qy - dy * qx;
        if (len2 == 0 || along < 0 || along > len2)
            return 1'b0;
        twice = 2 * ((perp < 0) ? -perp : perp);
        lim   = longint'(brush_w) * longint'(brush_w) * len2;
        return (twice * twice) <= lim;
    endfunction

    always @(posedge i_clk) begin
        t_painted_pixel got;
        t_painted_pixel want;
        int             errs;
        errs = 0;
        if (!i_rst_n) begin
            seg_x0    <= '0;
            seg_y0    <= '0;
            seg_x1    <= '0;
            seg_y1    <= '0;
            brush_w   <= BRUSH_WIDTH_RST;
            brush_rgb <= '0;
            awaited_pixels.delete();
            o_fail_count  <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_X:     seg_x0    <= i_cfg_data[COORD_BITS-1:0];
                    CFG_START_Y:     seg_y0    <= i_cfg_data[COORD_BITS-1:0];
                    CFG_END_X:       seg_x1    <= i_cfg_data[COORD_BITS-1:0];
                    CFG_END_Y:       seg_y1    <= i_cfg_data[COORD_BITS-1:0];
                    CFG_BRUSH_WIDTH: brush_w   <= i_cfg_data[WIDTH_BITS-1:0];
                    CFG_BRUSH_RGB:   brush_rgb <= i_cfg_data[RGB_BITS-1:0];
                    default: ;
                endcase
            end

            if (i_res.valid && i_res.ready) begin
                got = '{i_res.out_x, i_res.out_y, i_res.paint, i_res.out_rgb};
                if (awaited_pixels.size() == 0) begin
                    $error("result for pixel (%0d,%0d) with no request waiting",
                           got.x, got.y);
                    errs++;
                end else begin
                    want = awaited_pixels.pop_front();
                    if (got.x !== want.x) begin
                        $error("out_x: expected %0d, got %0d", want.x, got.x);
                        errs++;
                    end
                    if (got.y !== want.y) begin
                        $error("out_y: expected %0d, got %0d", want.y, got.y);
                        errs++;
                    end
                    if (got.paint !== want.paint) begin
                        $error("paint at (%0d,%0d): expected %0b, got %0b",
                               want.x, want.y, want.paint, got.paint);
                        errs++;
                    end
                    if (got.rgb !== want.rgb) begin
                        $error("out_rgb: expected %06h, got %06h", want.rgb, got.rgb);
                        errs++;
                    end
                end
            end

            if (i_pix.valid && i_pix.ready)
                awaited_pixels.push_back('{i_pix.pixel_x, i_pix.pixel_y,
                                           pixel_in_stroke(i_pix.pixel_x, i_pix.pixel_y),
                                           brush_rgb});

            o_fail_count  <= o_fail_count + errs;
            o_outstanding <= awaited_pixels.size();
        end
    end

endmodule

// ===== tb/tb_thick_line_pixel_coverage.sv =====
`timescale 1ns / 1ps
// Top of the thick line pixel coverage testbench: clock, reset, stroke setup,
// pixel requests and result back-pressure; the verdict comes from tb_tlpc_checker.
// Depends on tlpc_pkg, tlpc_pix_if, tlpc_res_if, thick_line_pixel_coverage and tb_tlpc_checker.
module tb_thick_line_pixel_coverage;
    import tlpc_pkg::*;

    localparam int COORD_BITS      = COORD_BITS_DEF;
    localparam int COORD_MIN       = -(1 <<< (COORD_BITS - 1));
    localparam int COORD_MAX       = (1 <<< (COORD_BITS - 1)) - 1;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 236;
    localparam int HOLD_CYCLES     = 80;
    // Drain time after the last result comes back.
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 300000;

    // Register indexes beyond the last real register; writes there are dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    int  fail_count;
    int  outstanding;
    int  cycle_count;

    // The request side writes quiet_run and hold_off_asked nonblocking so the result
    // side sees a stable value; hold_off_done is written by the result side alone.
    logic quiet_run;
    int   hold_off_asked;
    int   hold_off_done;

    tlpc_pix_if #(.COORD_BITS(COORD_BITS)) pix_if ();
    tlpc_res_if #(.COORD_BITS(COORD_BITS)) res_if ();

    thick_line_pixel_coverage #(.COORD_BITS(COORD_BITS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    tb_tlpc_checker #(.COORD_BITS(COORD_BITS)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pix         (pix_if),
        .i_res         (res_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog. A run that hangs, for example because results stop coming,
    // ends here with the failure line.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_thick_line_pixel_coverage: done, errors");
            $finish;
        end
    end

    // Result side. Ready drops at random in about ten percent of cycles, except during a
    // quiet phase. When the request side asks for a hold-off, ready stays low
    // while pixel requests keep coming, so the pipeline fills and the block
    // has to push back on its input.
    initial begin
        res_if.ready  <= 1'b0;
        hold_off_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_asked > hold_off_done) begin
                hold_off_done++;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_if.ready <= i_rst_n && (quiet_run || ($urandom_range(0, 99) >= 10));
        end
    end

    // One configuration write, accepted at the next rising edge. The write
    // enable is left high so back-to-back writes never toggle it within a step.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Loads a whole stroke. Bits above each register's width carry random junk
    // that the block must ignore, and both unused indexes are written with
    // random data that must not disturb anything.
    task automatic set_stroke(input int sx, input int sy, input int ex, input int ey,
                              input int w, input logic [RGB_BITS-1:0] rgb);
        logic [CFG_DATA_BITS-1:0] word;
        write_reg(CFG_IDX_SPARE_LO, CFG_DATA_BITS'($urandom));
        word = CFG_DATA_BITS'($urandom);
        word[COORD_BITS-1:0] = COORD_BITS'(sx);
        write_reg(CFG_START_X, word);
        word[COORD_BITS-1:0] = COORD_BITS'(sy);
        write_reg(CFG_START_Y, word);
        word = CFG_DATA_BITS'($urandom);
        word[COORD_BITS-1:0] = COORD_BITS'(ex);
        write_reg(CFG_END_X, word);
        word[COORD_BITS-1:0] = COORD_BITS'(ey);
        write_reg(CFG_END_Y, word);
        word = CFG_DATA_BITS'($urandom);
        word[WIDTH_BITS-1:0] = WIDTH_BITS'(w);
        write_reg(CFG_BRUSH_WIDTH, word);
        write_reg(CFG_BRUSH_RGB, CFG_DATA_BITS'(rgb));
        write_reg(CFG_IDX_SPARE_HI, CFG_DATA_BITS'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Offers one pixel request and returns at the edge where it is taken.
    // Valid stays high afterwards so consecutive requests go back to back.
    task automatic send_pixel(input int x, input int y);
        if (!quiet_run && $urandom_range(0, 99) < 10) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.pixel_x <= COORD_BITS'(x);
        pix_if.pixel_y <= COORD_BITS'(y);
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // Waits until every result is back, then lets the pipeline drain.
    task automatic settle();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int clamp_coord(input int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int rand_coord();
        return COORD_MIN + int'($urandom_range(0, COORD_MAX - COORD_MIN));
    endfunction

    initial begin
        int sx, sy, ex, ey, w, span, margin;
        int lo_x, hi_x, lo_y, hi_y;
        int px, py;
        logic [RGB_BITS-1:0] rgb;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_START_X;
        i_cfg_data     <= '0;
        pix_if.valid   <= 1'b0;
        pix_if.pixel_x <= '0;
        pix_if.pixel_y <= '0;
        quiet_run      <= 1'b0;
        hold_off_asked <= 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Straight out of reset the segment has zero length, so nothing paints,
        // and the color passes through as zero.
        send_pixel(0, 0);
        send_pixel(1, 0);
        settle();

        // Horizontal segment of length ten, width four: the long edges sit
        // exactly two pixels off the axis and must count as inside, as must the
        // end caps and the corners.
        set_stroke(0, 0, 10, 0, 4, 24'h12_34_56);
        send_pixel(0, 0);
        send_pixel(10, 0);
        send_pixel(5, 2);
        send_pixel(5, -2);
        send_pixel(5, 3);
        send_pixel(10, 2);
        send_pixel(-1, 0);
        send_pixel(11, 0);
        settle();

        // Zero width: only pixels on the segment itself paint.
        set_stroke(0, 0, 10, 0, 0, 24'hA5_5A_0F);
        send_pixel(5, 0);
        send_pixel(5, 1);
        send_pixel(0, 0);
        send_pixel(10, 0);
        settle();

        // Full-range diagonal at the widest brush and the brightest color,
        // probed at the corners of the coordinate space.
        set_stroke(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 255, 24'hFF_FF_FF);
        send_pixel(COORD_MIN, COORD_MIN);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(COORD_MAX, COORD_MIN);
        send_pixel(COORD_MIN, COORD_MAX);
        send_pixel(0, 0);
        send_pixel(-1, 1);
        settle();

        // Random phases. Each one sets a fresh stroke and then scans mostly
        // inside its bounding box, the way a rasterizer would, with some pixels
        // from anywhere in the coordinate space.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            sx = rand_coord();
            sy = rand_coord();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: span = 40;
                5, 6, 7:       span = 600;
                default:       span = COORD_MAX - COORD_MIN;
            endcase
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
            w  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
                                              : int'($urandom_range(0, 24));
            rgb = RGB_BITS'($urandom);
            if (phase == 0) begin
                // Opposite diagonal at the coordinate extremes, widest brush.
                sx = COORD_MAX;
                sy = COORD_MIN;
                ex = COORD_MIN;
                ey = COORD_MAX;
                w  = 255;
                rgb = '0;
            end else if (phase == 1) begin
                // Degenerate segment: a whole phase that must paint nothing.
                ex = sx;
                ey = sy;
            end else if (phase == 2) begin
                w = 0;
            end

            settle();
            set_stroke(sx, sy, ex, ey, w, rgb);
            quiet_run <= (phase == 3);
            if (phase == 2 || phase == 6)
                hold_off_asked <= hold_off_asked + 1;

            margin = w / 2 + 2;
            lo_x = clamp_coord(((sx < ex) ? sx : ex) - margin);
            hi_x = clamp_coord(((sx > ex) ? sx : ex) + margin);
            lo_y = clamp_coord(((sy < ey) ? sy : ey) - margin);
            hi_y = clamp_coord(((sy > ey) ? sy : ey) + margin);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    px = lo_x + int'($urandom_range(0, hi_x - lo_x));
                    py = lo_y + int'($urandom_range(0, hi_y - lo_y));
                end else begin
                    px = rand_coord();
                    py = rand_coord();
                end
                send_pixel(px, py);
            end
        end

        settle();
        if (fail_count == 0)
            $display("tb_thick_line_pixel_coverage: done, clean");
        else
            $display("tb_thick_line_pixel_coverage: done, errors");
        $finish;
    end

endmodule
